// File: hdl/gwws_pkg.sv
// Shared types, constants and helpers for the greedy word wrap stream block.
// Used by gwws_front, gwws_queue, gwws_back and greedy_word_wrap_stream.
package gwws_pkg;

    localparam int MAX_WIDTH = 60;
    localparam int STORE_AW  = $clog2(MAX_WIDTH);
    localparam int LINE_SAT  = 63;

    localparam logic [5:0] WIDTH_RESET = 6'd40;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef logic [5:0] len_t;

    // One command per input beat that produces output. The back end plays the
    // parts in this order: paragraph break, space, word bytes, newline, status.
    typedef struct packed {
        logic para;
        logic space;
        len_t word_len;
        logic nl;
        logic stat;
        logic term;
        logic err;
    } cmd_t;

    typedef struct packed {
        logic                en;
        logic [STORE_AW-1:0] addr;
        logic [7:0]          data;
    } store_wr_t;

    typedef struct packed {
        logic word_done;
    } back_status_t;

    // Saturating line length update.
    function automatic len_t sat_line(input len_t cur, input logic [6:0] add);
        logic [7:0] sum;
        begin
            sum = {2'b00, cur} + {1'b0, add};
            sat_line = (sum > 8'(LINE_SAT)) ? len_t'(LINE_SAT) : sum[5:0];
        end
    endfunction

endpackage

// File: hdl/greedy_word_wrap_stream.sv
// Top level of the streaming greedy word wrapper.
// Depends on gwws_pkg, gwws_front, gwws_queue and gwws_back.
//
// Usage: text enters one byte per beat on s_ch (s_valid/s_ready); a zero byte
// ends a text. Wrapped text leaves on the m_ channel, one byte per beat, with
// m_char_valid low only on the status beat of an empty text. m_last_of_run
// marks the last beat caused by one input byte; m_text_end and m_wrap_error
// sit on the final beat of a text, and a set m_wrap_error means the receiver
// should discard that text. The line width is written on cfg_valid/cfg_data
// (cfg_ready is always high) while the block is idle; values above 60 act
// as 60.
// Timing: with the receiver ready, a command goes from the front through the two-entry queue
// to the back end, which takes it while idle and then plays a space, newline or status beat
// from its emit state; a word goes through the emit state and then, for each byte, a store
// read (fetch) and an output register load (word data) before that byte's beat is offered.
// A word byte is held off while an earlier word is still being read out.
// Reset clears all line and word state and sets the width to 40; the word
// store needs no clearing pass. When the receiver stalls, the output register
// holds its beat, the back end waits, and the front keeps accepting bytes
// until the queue fills.
module greedy_word_wrap_stream
    import gwws_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_ch,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_char_valid,
    output logic       m_text_end,
    output logic       m_wrap_error,
    output logic       m_last_of_run
);

    logic         q_push;
    cmd_t         q_cmd;
    logic         q_full;
    logic         q_pop;
    cmd_t         q_head;
    logic         q_empty;
    store_wr_t    store_wr;
    back_status_t back_status;

    // The front owns all per-text state and decides what each byte produces.
    gwws_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_ch        (s_ch),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .q_push      (q_push),
        .q_cmd       (q_cmd),
        .q_full      (q_full),
        .store_wr    (store_wr),
        .back_status (back_status)
    );

    // The queue lets the front run ahead of a stalled output.
    gwws_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head_cmd (q_head),
        .empty    (q_empty)
    );

    // The back end turns each command into result beats.
    gwws_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .store_wr      (store_wr),
        .head_cmd      (q_head),
        .q_empty       (q_empty),
        .q_pop         (q_pop),
        .back_status   (back_status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_char_valid  (m_char_valid),
        .m_text_end    (m_text_end),
        .m_wrap_error  (m_wrap_error),
        .m_last_of_run (m_last_of_run)
    );

endmodule

// File: hdl/gwws_front.sv
// Front end: accepts text beats, keeps the line and word state, writes word
// bytes to the store and issues commands to the queue. Depends on gwws_pkg.
module gwws_front
    import gwws_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_ch,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [5:0]   cfg_data,
    output logic         q_push,
    output cmd_t         q_cmd,
    input  logic         q_full,
    output store_wr_t    store_wr,
    input  back_status_t back_status
);

    len_t       line_width_reg;
    len_t       word_len_reg, word_len_next;
    len_t       line_len_reg, line_len_next;
    logic       nl_seen_reg, nl_seen_next;
    logic       para_reg, para_next;
    logic       err_reg, err_next;
    logic [1:0] word_cnt_reg, word_cnt_next;

    len_t       width_eff;
    len_t       line_base;
    logic       is_sep;
    logic       is_term;
    logic       accept;
    logic       overflow;
    logic       has_cmd;

    assign cfg_ready = 1'b1;
    assign is_term   = (s_ch == CH_NUL);
    assign is_sep    = (s_ch == CH_SPACE) || (s_ch == CH_TAB) || (s_ch == CH_LF);
    assign width_eff = (line_width_reg > len_t'(MAX_WIDTH)) ? len_t'(MAX_WIDTH)
                                                            : line_width_reg;

    // A word byte must wait until no earlier word is still being read out.
    assign s_ready = !q_full && (is_sep || is_term || (word_cnt_reg == 2'd0));
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && has_cmd;

    assign overflow = ({1'b0, word_len_reg} + 7'd1 > {1'b0, width_eff})
                   || (word_len_reg >= len_t'(MAX_WIDTH));

    always_comb begin
        word_len_next = word_len_reg;
        line_len_next = line_len_reg;
        nl_seen_next  = nl_seen_reg;
        para_next     = para_reg;
        err_next      = err_reg;
        q_cmd         = '0;
        has_cmd       = 1'b0;
        store_wr      = '0;
        line_base     = line_len_reg;
        if (accept) begin
            if (is_term) begin
                q_cmd.space    = (word_len_reg != '0) && (line_len_reg != '0);
                q_cmd.word_len = word_len_reg;
                q_cmd.nl       = (word_len_reg != '0) || (line_len_reg != '0);
                q_cmd.stat     = (word_len_reg == '0) && (line_len_reg == '0);
                q_cmd.term     = 1'b1;
                q_cmd.err      = err_reg;
                has_cmd        = 1'b1;
                word_len_next  = '0;
                line_len_next  = '0;
                nl_seen_next   = 1'b0;
                para_next      = 1'b0;
                err_next       = 1'b0;
            end else if (is_sep) begin
                if (word_len_reg != '0) begin
                    q_cmd.space    = (line_len_reg != '0);
                    q_cmd.word_len = word_len_reg;
                    has_cmd        = 1'b1;
                    line_len_next  = sat_line(line_len_reg,
                        7'(word_len_reg) + 7'(line_len_reg != '0));
                    word_len_next  = '0;
                    if (s_ch == CH_LF) begin
                        nl_seen_next = 1'b1;
                    end
                end else if (nl_seen_reg && (s_ch == CH_LF)) begin
                    para_next = 1'b1;
                end else begin
                    nl_seen_next = (s_ch == CH_LF);
                end
            end else begin
                nl_seen_next = 1'b0;
                q_cmd.para   = para_reg;
                para_next    = 1'b0;
                if (para_reg) begin
                    line_base = '0;
                end
                if (overflow) begin
                    err_next = 1'b1;
                end else begin
                    store_wr.en   = 1'b1;
                    store_wr.addr = word_len_reg[STORE_AW-1:0];
                    store_wr.data = s_ch;
                    word_len_next = word_len_reg + 6'd1;
                    // Break before the word once a space plus the word no longer fits.
                    if ((line_base != '0) && ({2'b00, word_len_reg} + 8'd2
                            + {2'b00, line_base} > {2'b00, width_eff})) begin
                        q_cmd.nl  = 1'b1;
                        line_base = '0;
                    end
                end
                line_len_next = line_base;
                has_cmd       = q_cmd.para || q_cmd.nl;
            end
        end
    end

    always_comb begin
        word_cnt_next = word_cnt_reg;
        if (q_push && (q_cmd.word_len != '0) && !back_status.word_done) begin
            word_cnt_next = word_cnt_reg + 2'd1;
        end else if (!(q_push && (q_cmd.word_len != '0)) && back_status.word_done) begin
            word_cnt_next = word_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_width_reg <= WIDTH_RESET;
            word_len_reg   <= '0;
            line_len_reg   <= '0;
            nl_seen_reg    <= 1'b0;
            para_reg       <= 1'b0;
            err_reg        <= 1'b0;
            word_cnt_reg   <= '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                line_width_reg <= cfg_data;
            end
            word_len_reg <= word_len_next;
            line_len_reg <= line_len_next;
            nl_seen_reg  <= nl_seen_next;
            para_reg     <= para_next;
            err_reg      <= err_next;
            word_cnt_reg <= word_cnt_next;
        end
    end

endmodule

// File: hdl/gwws_queue.sv
// Two-entry command queue between the front and back ends.
// Depends on gwws_pkg for the command type.
module gwws_queue
    import gwws_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head_cmd,
    output logic empty
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if ((push && !full) && !(pop && !empty)) begin
                count_reg <= count_reg + 2'd1;
            end else if (!(push && !full) && (pop && !empty)) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// File: hdl/gwws_back.sv
// Back end: holds the word store, plays queued commands out as result beats
// through a registered output stage. Depends on gwws_pkg.
module gwws_back
    import gwws_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  store_wr_t    store_wr,
    input  cmd_t         head_cmd,
    input  logic         q_empty,
    output logic         q_pop,
    output back_status_t back_status,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [7:0]   m_out_char,
    output logic         m_char_valid,
    output logic         m_text_end,
    output logic         m_wrap_error,
    output logic         m_last_of_run
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_EMIT  = 4'b0010,
        ST_FETCH = 4'b0100,
        ST_WDATA = 4'b1000
    } state_t;

    localparam int F_PARA1 = 0;
    localparam int F_PARA2 = 1;
    localparam int F_SPACE = 2;
    localparam int F_WORD  = 3;
    localparam int F_NL    = 4;
    localparam int F_STAT  = 5;

    logic [7:0] store_mem [MAX_WIDTH];
    logic [7:0] mem_q_reg;

    state_t              state_reg, state_next;
    logic [5:0]          flags_reg, flags_next;
    len_t                len_reg, len_next;
    logic [STORE_AW-1:0] idx_reg, idx_next;
    logic                term_reg, term_next;
    logic                err_reg, err_next;

    logic       m_valid_reg, m_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       char_valid_reg, char_valid_next;
    logic       text_end_reg, text_end_next;
    logic       wrap_error_reg, wrap_error_next;
    logic       last_reg, last_next;

    logic       out_free;
    logic [5:0] pick;
    logic [5:0] rest;
    logic [5:0] rest_word;
    logic       last_byte;

    assign out_free  = !m_valid_reg || m_ready;
    assign pick      = flags_reg & (~flags_reg + 6'd1);
    assign rest      = flags_reg & ~pick;
    assign rest_word = flags_reg & ~(6'd1 << F_WORD);
    assign last_byte = ({1'b0, idx_reg} == ({1'b0, len_reg} - 7'd1));
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    always_ff @(posedge aclk) begin
        if (store_wr.en) begin
            store_mem[store_wr.addr] <= store_wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_FETCH) begin
            mem_q_reg <= store_mem[idx_reg];
        end
    end

    always_comb begin
        state_next      = state_reg;
        flags_next      = flags_reg;
        len_next        = len_reg;
        idx_next        = idx_reg;
        term_next       = term_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        out_char_next   = out_char_reg;
        char_valid_next = char_valid_reg;
        text_end_next   = text_end_reg;
        wrap_error_next = wrap_error_reg;
        last_next       = last_reg;
        back_status     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_empty) begin
                    flags_next[F_PARA1] = head_cmd.para;
                    flags_next[F_PARA2] = head_cmd.para;
                    flags_next[F_SPACE] = head_cmd.space;
                    flags_next[F_WORD]  = (head_cmd.word_len != '0);
                    flags_next[F_NL]    = head_cmd.nl;
                    flags_next[F_STAT]  = head_cmd.stat;
                    len_next            = head_cmd.word_len;
                    idx_next            = '0;
                    term_next           = head_cmd.term;
                    err_next            = head_cmd.err;
                    state_next          = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (pick == '0) begin
                    state_next = ST_IDLE;
                end else if (pick[F_WORD]) begin
                    state_next = ST_FETCH;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_char_next   = pick[F_SPACE] ? CH_SPACE
                                    : (pick[F_STAT] ? CH_NUL : CH_LF);
                    char_valid_next = !pick[F_STAT];
                    last_next       = (rest == '0);
                    text_end_next   = term_reg && (rest == '0);
                    wrap_error_next = err_reg && term_reg && (rest == '0);
                    flags_next      = rest;
                    state_next      = (rest == '0) ? ST_IDLE : ST_EMIT;
                end
            end
            ST_FETCH: begin
                state_next = ST_WDATA;
            end
            ST_WDATA: begin
                if (out_free) begin
                    m_valid_next    = 1'b1;
                    out_char_next   = mem_q_reg;
                    char_valid_next = 1'b1;
                    last_next       = last_byte && (rest_word == '0);
                    text_end_next   = term_reg && last_byte && (rest_word == '0);
                    wrap_error_next = err_reg && term_reg && last_byte
                                   && (rest_word == '0);
                    if (last_byte) begin
                        flags_next            = rest_word;
                        back_status.word_done = 1'b1;
                        state_next            = (rest_word == '0) ? ST_IDLE : ST_EMIT;
                    end else begin
                        idx_next   = idx_reg + STORE_AW'(1);
                        state_next = ST_FETCH;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            flags_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            flags_reg   <= flags_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        len_reg        <= len_next;
        idx_reg        <= idx_next;
        term_reg       <= term_next;
        err_reg        <= err_next;
        out_char_reg   <= out_char_next;
        char_valid_reg <= char_valid_next;
        text_end_reg   <= text_end_next;
        wrap_error_reg <= wrap_error_next;
        last_reg       <= last_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = out_char_reg;
    assign m_char_valid  = char_valid_reg;
    assign m_text_end    = text_end_reg;
    assign m_wrap_error  = wrap_error_reg;
    assign m_last_of_run = last_reg;

endmodule

// File: tb/testbench.sv
// Self-checking testbench for greedy_word_wrap_stream: directed and random text streams under several widths.
// It predicts every wrapped output beat itself and depends only on gwws_pkg and the block's RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import gwws_pkg::*;

    // Line length never grows past this value; it saturates instead.
    localparam int LINE_CAP      = 63;
    localparam int DIRECTED_MAX  = 25;
    localparam int RANDOM_ITEMS  = 230;
    // Cycles allowed for bytes that produce no output to work their way through the block.
    localparam int SETTLE_CYCLES = 24;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 3000;

    // One output beat as the block should present it.
    typedef struct packed {
        logic [7:0] out_char;
        logic       char_valid;
        logic       text_end;
        logic       wrap_error;
        logic       last_of_run;
    } wrap_beat_t;

    logic       aclk          = 1'b0;
    logic       aresetn       = 1'b0;
    logic       s_valid       = 1'b0;
    logic       s_ready;
    logic [7:0] s_ch          = 8'h00;
    logic       cfg_valid     = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data      = 6'd0;
    logic       m_valid;
    logic       m_ready       = 1'b0;
    logic [7:0] m_out_char;
    logic       m_char_valid;
    logic       m_text_end;
    logic       m_wrap_error;
    logic       m_last_of_run;

    greedy_word_wrap_stream i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_ch          (s_ch),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_char_valid  (m_char_valid),
        .m_text_end    (m_text_end),
        .m_wrap_error  (m_wrap_error),
        .m_last_of_run (m_last_of_run)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Shared bookkeeping between stimulus, sender, receiver and checker.
    // ------------------------------------------------------------------
    logic [7:0] pending_text [$];   // text bytes waiting for the sender
    wrap_beat_t wrapped_out  [$];   // output beats predicted but not yet seen

    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int beats_out     = 0;
    int texts_done    = 0;
    int texts_flagged = 0;
    int widths_tried  = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;

    int s_idle_max = 11;
    int r_idle_max = 11;
    int s_gap      = 0;
    int r_gap      = 0;
    bit s_fire     = 1'b0;
    bit m_fire     = 1'b0;
    bit hold_req   = 1'b0;
    int hold_left  = 0;

    // ------------------------------------------------------------------
    // Predictor state: a private copy of the wrapper's line and word state.
    // ------------------------------------------------------------------
    logic [7:0] word_buf [MAX_WIDTH];
    int         word_len  = 0;
    int         line_len  = 0;
    bit         nl_seen   = 1'b0;
    bit         para_due  = 1'b0;
    bit         err_seen  = 1'b0;
    logic [5:0] width_reg = WIDTH_RESET;

    function automatic void put_char(logic [7:0] c);
        wrap_beat_t b;
        b            = '0;
        b.out_char   = c;
        b.char_valid = 1'b1;
        wrapped_out.push_back(b);
    endfunction

    function automatic void grow_line(int k);
        line_len = (line_len + k > LINE_CAP) ? LINE_CAP : line_len + k;
    endfunction

    // Emits the buffered word, preceded by a space when the line already holds text.
    function automatic void flush_word();
        int i;
        if (line_len > 0) begin
            put_char(CH_SPACE);
            grow_line(1);
        end
        for (i = 0; i < word_len; i++)
            put_char(word_buf[i]);
        grow_line(word_len);
        word_len = 0;
    endfunction

    // Works out every output beat that one accepted text byte causes.
    function automatic void wrap_byte(logic [7:0] c);
        int         first;
        int         w;
        bit         is_sep;
        wrap_beat_t tail;
        first  = wrapped_out.size();
        w      = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        is_sep = (c == CH_SPACE || c == CH_TAB || c == CH_LF);

        if (c == CH_NUL) begin
            // The terminator closes the text; a pending paragraph break is simply dropped.
            if (word_len > 0)
                flush_word();
            if (line_len > 0)
                put_char(CH_LF);
            if (wrapped_out.size() == first) begin
                tail = '0;
                wrapped_out.push_back(tail);
            end
        end else if (is_sep && word_len > 0) begin
            flush_word();
            if (c == CH_LF)
                nl_seen = 1'b1;
        end else if (!is_sep) begin
            nl_seen = 1'b0;
            if (para_due) begin
                put_char(CH_LF);
                put_char(CH_LF);
                line_len = 0;
                para_due = 1'b0;
            end
            if (word_len + 1 > w || word_len >= MAX_WIDTH) begin
                // The byte does not fit in any line: it is dropped and the text is flagged.
                err_seen = 1'b1;
            end else begin
                word_buf[word_len] = c;
                word_len++;
                if (line_len > 0 && 1 + word_len + line_len > w) begin
                    put_char(CH_LF);
                    line_len = 0;
                end
            end
        end else if (nl_seen && c == CH_LF) begin
            para_due = 1'b1;
        end else begin
            nl_seen = (c == CH_LF);
        end

        if (wrapped_out.size() > first) begin
            tail             = wrapped_out[wrapped_out.size() - 1];
            tail.last_of_run = 1'b1;
            if (c == CH_NUL) begin
                tail.text_end   = 1'b1;
                tail.wrap_error = err_seen;
            end
            wrapped_out[wrapped_out.size() - 1] = tail;
        end

        if (c == CH_NUL) begin
            word_len = 0;
            line_len = 0;
            nl_seen  = 1'b0;
            para_due = 1'b0;
            err_seen = 1'b0;
        end
    endfunction

    task automatic report_mismatch(string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // ------------------------------------------------------------------
    // Monitor. Everything seen at a rising edge is handled in this one
    // process, so a byte is always predicted before any beat it causes is
    // checked, independent of scheduling order.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : monitor
        wrap_beat_t want;
        s_fire <= aresetn && s_valid && s_ready;
        m_fire <= aresetn && m_valid && m_ready;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                width_reg = cfg_data;
            if (s_valid && s_ready) begin
                wrap_byte(s_ch);
                bytes_taken++;
            end
            if (m_valid && m_ready) begin
                beats_out++;
                if (wrapped_out.size() == 0) begin
                    report_mismatch($sformatf("output beat %0d (char 0x%02h) was not expected",
                                              beats_out, m_out_char));
                end else begin
                    want = wrapped_out.pop_front();
                    if (m_out_char !== want.out_char)
                        report_mismatch($sformatf("beat %0d out_char 0x%02h, expected 0x%02h",
                                                  beats_out, m_out_char, want.out_char));
                    if (m_char_valid !== want.char_valid)
                        report_mismatch($sformatf("beat %0d char_valid %b, expected %b",
                                                  beats_out, m_char_valid, want.char_valid));
                    if (m_text_end !== want.text_end)
                        report_mismatch($sformatf("beat %0d text_end %b, expected %b",
                                                  beats_out, m_text_end, want.text_end));
                    if (m_wrap_error !== want.wrap_error)
                        report_mismatch($sformatf("beat %0d wrap_error %b, expected %b",
                                                  beats_out, m_wrap_error, want.wrap_error));
                    if (m_last_of_run !== want.last_of_run)
                        report_mismatch($sformatf("beat %0d last_of_run %b, expected %b",
                                                  beats_out, m_last_of_run, want.last_of_run));
                    if (want.text_end) begin
                        texts_done++;
                        if (want.wrap_error)
                            texts_flagged++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender. Inputs change on the falling edge only. After each beat it
    // draws a gap before offering the next byte; once valid is up it stays
    // up with the same byte until the beat is taken.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : sender
        logic next_valid;
        next_valid = s_valid;
        if (s_fire)
            next_valid = 1'b0;
        if (aresetn && !next_valid) begin
            if (s_gap > 0) begin
                s_gap--;
            end else if (pending_text.size() > 0) begin
                s_ch <= pending_text.pop_front();
                next_valid = 1'b1;
                s_gap = $urandom_range(0, s_idle_max);
            end
        end
        s_valid <= next_valid;
    end

    // ------------------------------------------------------------------
    // Receiver. After each accepted beat it draws how long to drop ready.
    // A long hold, when requested, is counted down here on its own.
    // ------------------------------------------------------------------
    always @(negedge aclk) begin : receiver
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (m_fire)
            r_gap = $urandom_range(0, r_idle_max);
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (r_gap > 0) begin
            r_gap--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // The watchdog ends a run in which no beat of any kind moves for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d beats still expected",
                     quiet_cycles, wrapped_out.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic send(logic [7:0] c);
        pending_text.push_back(c);
        bytes_queued++;
    endtask

    // Any byte that is neither a separator nor the terminator.
    function automatic logic [7:0] word_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CH_SPACE || c == CH_TAB || c == CH_LF);
        return c;
    endfunction

    // Waits until every byte is taken and every predicted beat has arrived,
    // then lets the pipeline settle, since a separator may still be in flight.
    task automatic wait_drained();
        while (bytes_taken != bytes_queued || wrapped_out.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // The width register is only written with the block idle.
    task automatic set_width(logic [5:0] w);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= w;
        do
            @(posedge aclk);
        while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        widths_tried++;
    endtask

    // A run of separators: single ones, mixed runs, and double or triple
    // newlines that ask for a paragraph break.
    task automatic send_separators();
        int k;
        case ($urandom_range(0, 5))
            0: send(CH_SPACE);
            1: send(CH_TAB);
            2: send(CH_LF);
            3: begin
                send(CH_LF);
                send(CH_LF);
            end
            4: begin
                send(CH_LF);
                send(CH_LF);
                send(CH_LF);
            end
            default: begin
                k = $urandom_range(2, 4);
                repeat (k) begin
                    case ($urandom_range(0, 2))
                        0: send(CH_SPACE);
                        1: send(CH_TAB);
                        default: send(CH_LF);
                    endcase
                end
            end
        endcase
    endtask

    // Mostly well-formed texts with random words, sized for the width in force,
    // with a little raw noise and the odd early terminator mixed in.
    task automatic random_phase(int width_set, bit pause_midway);
        int w;
        int goal;
        int start;
        int len;
        w     = (width_set > MAX_WIDTH) ? MAX_WIDTH : width_set;
        goal  = $urandom_range(25, 45);
        start = bytes_queued;
        while (bytes_queued - start < goal) begin
            if (pause_midway && bytes_queued - start >= goal / 2) begin
                // The sender stops here until the block has given every result.
                wait_drained();
                pause_midway = 1'b0;
            end
            case ($urandom_range(0, 19))
                0: send(8'($urandom_range(0, 255)));
                1: send(CH_NUL);
                default: begin
                    if (w == 0)
                        len = $urandom_range(1, 3);
                    else if ($urandom_range(0, 9) == 0)
                        len = w + $urandom_range(1, 3);
                    else if ($urandom_range(0, 5) == 0)
                        len = $urandom_range(1, w);
                    else
                        len = $urandom_range(1, (w < 6) ? w : 6);
                    repeat (len) send(word_char());
                    send_separators();
                end
            endcase
        end
        // Some phases leave the text open, so a width change lands mid-text.
        if ($urandom_range(0, 2) != 0)
            send(CH_NUL);
    endtask

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin : stimulus
        int    phase;
        int    width_set;
        int    directed_count;
        int    fixed_widths [6];
        fixed_widths = '{60, 63, 1, 0, 61, 40};

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset width of 40: an empty text, separators
        // alone, a paragraph break before a word, extreme byte values, and a
        // paragraph break still pending when the text ends.
        send(CH_NUL);
        send(CH_TAB);
        send(CH_SPACE);
        send(CH_LF);
        send(CH_LF);
        send(8'h41);
        send(8'hFF);
        send(8'h01);
        send(CH_SPACE);
        send(8'h7F);
        send(CH_LF);
        send(CH_LF);
        send(CH_NUL);

        // At width 1 the second byte of a word overflows, and the next word
        // forces a break onto a new line.
        set_width(6'd1);
        send(8'h78);
        send(8'h79);
        send(CH_SPACE);
        send(8'h7A);
        send(CH_NUL);

        // At width 0 every word byte overflows; the text ends with a status beat only.
        set_width(6'd0);
        send(8'h80);
        send(CH_SPACE);
        send(CH_NUL);
        directed_count = bytes_queued;
        if (directed_count > DIRECTED_MAX)
            $display("Note: directed part grew to %0d bytes", directed_count);

        // Random part, one phase per width setting.
        phase = 0;
        while (bytes_queued - directed_count < RANDOM_ITEMS) begin
            width_set = (phase < 6) ? fixed_widths[phase] : $urandom_range(1, MAX_WIDTH);
            set_width(6'(width_set));
            if (phase % 3 == 2) begin
                s_idle_max = 0;
                r_idle_max = 0;
            end else begin
                s_idle_max = 11;
                r_idle_max = 11;
            end
            if (phase == 1) begin
                // The receiver stalls for a long stretch while the sender keeps
                // offering bytes, so the block's queue fills and s_ready drops.
                s_idle_max = 0;
                hold_req   = 1'b1;
            end
            random_phase(width_set, phase % 2 == 0);
            phase++;
        end

        wait_drained();
        if (wrapped_out.size() != 0)
            report_mismatch($sformatf("%0d expected beats never arrived", wrapped_out.size()));

        $display("Sent %0d text bytes and checked %0d output beats under %0d width settings.",
                 bytes_queued, beats_out, widths_tried);
        $display("%0d texts were closed, %0d of them flagged for an overlong word.",
                 texts_done, texts_flagged);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
